// ===== hdl/hta_pkg.sv =====
// handle table allocator package
// payload widths and operation codes shared by the interfaces and the core
`timescale 1ns / 1ps

package hta_pkg;

   localparam int OPERATION_WIDTH = 2;
   localparam int HANDLE_WIDTH    = 10;
   localparam int DATA_WIDTH      = 32;

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_TAKE = 2'd0,
      OP_GIVE = 2'd1,
      OP_SET  = 2'd2,
      OP_GET  = 2'd3
   } op_type;

endpackage

// ===== hdl/hta_req_if.sv =====
// request channel of the handle table allocator
// valid/ready handshake carrying operation, handle and value; uses hta_pkg
`timescale 1ns / 1ps

interface hta_req_if import hta_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic [OPERATION_WIDTH-1:0] operation;
   logic [HANDLE_WIDTH-1:0]    handle_in;
   logic [DATA_WIDTH-1:0]      value_in;

   modport source (output valid, output operation, output handle_in, output value_in,
                   input ready);
   modport sink   (input valid, input operation, input handle_in, input value_in,
                   output ready);

endinterface

// ===== hdl/hta_rsp_if.sv =====
// response channel of the handle table allocator
// valid/ready handshake carrying handle, value and status; uses hta_pkg
`timescale 1ns / 1ps

interface hta_rsp_if import hta_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [HANDLE_WIDTH-1:0] handle_out;
   logic [DATA_WIDTH-1:0]   value_out;
   logic                    ok;

   modport source (output valid, output handle_out, output value_out, output ok,
                   input ready);
   modport sink   (input valid, input handle_out, input value_out, input ok,
                   output ready);

endinterface

// ===== hdl/handle_table_allocator_core.sv =====
// handle table allocator core
// taken-word and value memories with read-modify-write; uses hta_pkg, hta_req_if, hta_rsp_if
`timescale 1ns / 1ps

// At acceptance the group's taken word and the addressed value are read from
// their synchronous memories, and in the execute step the word is modified, the
// memories are written back as the operation requires and the response is
// registered. A take finds its group by priority encoding a per-group full flag and
// its slot by priority encoding the free bits of that word. Per-group held flags
// and a per-slot live mask kept beside the taken bits stand in for cleared
// contents, so the block is ready straight after reset with no clearing pass. A
// response that is not taken holds the next transaction before its execute step.
module handle_table_allocator_core import hta_pkg::*; #(
   parameter int GROUP_SIZE  = 32,
   parameter int GROUP_COUNT = 32,
   parameter int VALUE_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   hta_req_if.sink   req_bus,
   hta_rsp_if.source rsp_bus
);

   localparam int GW          = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int SW          = $clog2(GROUP_SIZE);
   localparam int SLOT_TOTAL  = GROUP_COUNT * GROUP_SIZE;
   localparam int AW          = $clog2(SLOT_TOTAL);
   localparam int RECIP_SHIFT = HANDLE_WIDTH + 7;
   localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'(((1 << RECIP_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);

   logic [2*GROUP_SIZE-1:0] taken_mem [GROUP_COUNT];
   logic [VALUE_WIDTH-1:0]  value_mem [SLOT_TOTAL];

   logic                    exec_ff, exec_in;
   op_type                  op_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [DATA_WIDTH-1:0]   value_ff;
   logic [HANDLE_WIDTH-1:0] grp_ff;
   logic                    range_ok_ff;
   logic                    held_sel_ff;
   logic [2*GROUP_SIZE-1:0] word_rd_ff;
   logic [VALUE_WIDTH-1:0]  value_rd_ff;
   logic [GROUP_COUNT-1:0]  held_ff, held_in;
   logic [GROUP_COUNT-1:0]  full_ff, full_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff;
   logic [DATA_WIDTH-1:0]   rsp_value_ff;
   logic                    rsp_ok_ff;

   logic                                accept;
   logic                                exec_fire;
   op_type                              req_op;
   logic [HANDLE_WIDTH+RECIP_SHIFT-1:0] recip_prod;
   logic [HANDLE_WIDTH-1:0]             req_grp;
   logic [GW-1:0]                       take_grp;
   logic                                any_free;
   logic [GW-1:0]                       acc_idx;
   logic                                acc_range;

   logic [GW-1:0]           idx;
   logic [GROUP_SIZE-1:0]   taken_cur, live_cur, taken_new, live_new, onehot;
   logic [SW-1:0]           slot_take, slot_h, slot;
   logic                    taken_bit, live_bit;
   logic                    ok;
   logic                    mem_we, val_we;
   logic [AW-1:0]           val_waddr;
   logic [VALUE_WIDTH-1:0]  val_wdata;
   logic [HANDLE_WIDTH-1:0] handle_res;
   logic [DATA_WIDTH-1:0]   value_res;

   // acceptance side
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !exec_ff;
   assign exec_fire     = exec_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_op        = op_type'(req_bus.operation);
   assign recip_prod    = HANDLE_WIDTH'(req_bus.handle_in) * RECIP;
   assign req_grp       = recip_prod[RECIP_SHIFT +: HANDLE_WIDTH];

   always_comb begin
      take_grp = '0;
      any_free = 1'b0;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (!full_ff[g]) begin
            take_grp = GW'(g);
            any_free = 1'b1;
         end
      end
   end

   assign acc_idx   = (req_op == OP_TAKE) ? take_grp : req_grp[GW-1:0];
   assign acc_range = (req_op == OP_TAKE) ? any_free : (int'(req_grp) < GROUP_COUNT);

   // execute side
   assign idx       = grp_ff[GW-1:0];
   assign taken_cur = held_sel_ff ? word_rd_ff[GROUP_SIZE-1:0] : '0;
   assign live_cur  = held_sel_ff ? word_rd_ff[2*GROUP_SIZE-1:GROUP_SIZE] : '0;
   assign slot_h    = SW'(handle_ff - HANDLE_WIDTH'(int'(grp_ff) * GROUP_SIZE));

   always_comb begin
      slot_take = '0;
      for (int s = GROUP_SIZE - 1; s >= 0; s--) begin
         if (!taken_cur[s]) begin
            slot_take = SW'(s);
         end
      end
   end

   assign slot      = (op_ff == OP_TAKE) ? slot_take : slot_h;
   assign onehot    = GROUP_SIZE'(1) << slot;
   assign taken_bit = |(taken_cur & onehot);
   assign live_bit  = |(live_cur & onehot);
   assign val_waddr = AW'(int'(idx) * GROUP_SIZE + int'(slot));

   always_comb begin
      ok         = 1'b0;
      mem_we     = 1'b0;
      val_we     = 1'b0;
      val_wdata  = '1;
      taken_new  = taken_cur;
      live_new   = live_cur;
      handle_res = '0;
      value_res  = '0;
      held_in    = held_ff;
      full_in    = full_ff;
      case (op_ff)
         OP_TAKE: begin
            ok        = range_ok_ff;
            taken_new = taken_cur | onehot;
            live_new  = live_cur | onehot;
            mem_we    = ok;
            val_we    = ok;
            val_wdata = '1;
            if (ok) begin
               handle_res = HANDLE_WIDTH'(int'(idx) * GROUP_SIZE + int'(slot));
            end
            if (exec_fire && ok) begin
               held_in[idx] = 1'b1;
               full_in[idx] = &taken_new;
            end
         end
         OP_GIVE: begin
            ok        = range_ok_ff && taken_bit;
            taken_new = taken_cur & ~onehot;
            live_new  = live_cur & ~onehot;
            mem_we    = ok;
            if (exec_fire && ok) begin
               held_in[idx] = |taken_new;
               full_in[idx] = 1'b0;
            end
         end
         OP_SET: begin
            ok        = range_ok_ff && held_sel_ff;
            live_new  = live_cur | onehot;
            mem_we    = ok;
            val_we    = ok;
            val_wdata = VALUE_WIDTH'(value_ff);
         end
         OP_GET: begin
            ok = range_ok_ff && held_sel_ff;
            if (ok && live_bit) begin
               value_res = DATA_WIDTH'(value_rd_ff);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign exec_in      = accept ? 1'b1 : (exec_fire ? 1'b0 : exec_ff);
   assign rsp_valid_in = exec_fire ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         full_ff      <= '0;
      end else begin
         exec_ff      <= exec_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         full_ff      <= full_in;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         handle_ff   <= req_bus.handle_in;
         value_ff    <= req_bus.value_in;
         grp_ff      <= (req_op == OP_TAKE) ? HANDLE_WIDTH'(take_grp) : req_grp;
         range_ok_ff <= acc_range;
         held_sel_ff <= acc_range ? held_ff[acc_idx] : 1'b0;
      end
   end

   // taken and live words
   always_ff @(posedge clock) begin
      if (accept) begin
         word_rd_ff <= taken_mem[acc_idx];
      end
      if (exec_fire && mem_we) begin
         taken_mem[idx] <= {live_new, taken_new};
      end
   end

   // bound values
   always_ff @(posedge clock) begin
      if (accept) begin
         value_rd_ff <= value_mem[AW'(req_bus.handle_in)];
      end
      if (exec_fire && val_we) begin
         value_mem[val_waddr] <= val_wdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_handle_ff <= handle_res;
         rsp_value_ff  <= value_res;
         rsp_ok_ff     <= ok;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.handle_out = rsp_handle_ff;
   assign rsp_bus.value_out  = rsp_value_ff;
   assign rsp_bus.ok         = rsp_ok_ff;

endmodule
